// ===== rtl/core/lfls_pkg.sv =====
`timescale 1ns / 1ps

package lfls_pkg;

   // Request commands.
   typedef enum logic [1:0] {
      ACT_TICK        = 2'd0,
      ACT_END_WAIT    = 2'd1,
      ACT_CLEAR_LOCK  = 2'd2,
      ACT_TECH_RESET  = 2'd3
   } action_type;

   // Supervisor phases as reported on the response.
   typedef enum logic [1:0] {
      PH_CLEAR  = 2'd0,
      PH_ACTIVE = 2'd1,
      PH_WAIT   = 2'd2,
      PH_LOCK   = 2'd3
   } phase_type;

   // Event codes as reported on the response.
   typedef enum logic [1:0] {
      EV_NONE        = 2'd0,
      EV_LEAK_FAULT  = 2'd1,
      EV_WAIT_START  = 2'd2,
      EV_TECH_RESET  = 2'd3
   } event_type;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_WAIT_DURATION = 2'd0,
      REG_WINDOW_SEC    = 2'd1,
      REG_WINDOW_LIMIT  = 2'd2,
      REG_TOTAL_LIMIT   = 2'd3
   } reg_index_type;

   localparam logic [31:0] WAIT_DURATION_RST = 32'd3600000;
   localparam logic [31:0] WINDOW_SEC_RST    = 32'd86400;
   localparam logic [15:0] WINDOW_LIMIT_RST  = 16'd3;
   localparam logic [15:0] TOTAL_LIMIT_RST   = 16'd10;
   localparam logic [15:0] TOTAL_MAX         = 16'hFFFF;
   localparam logic [4:0]  WINDOW_CNT_MAX    = 5'd31;

   // Commands from the sequencer to the leak-time ring.
   typedef struct packed {
      logic push;
      logic clear;
      logic scan;
   } ring_ctrl_type;

   // Status from the ring back to the sequencer.
   typedef struct packed {
      logic done;
   } ring_stat_type;

endpackage

// ===== rtl/core/lfls_req_if.sv =====
`timescale 1ns / 1ps

interface lfls_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic        leak_wet;
   logic [31:0] now_ms;
   logic [31:0] time_sec;

   modport source (output valid, action, leak_wet, now_ms, time_sec, input ready);
   modport sink   (input valid, action, leak_wet, now_ms, time_sec, output ready);
endinterface

// ===== rtl/core/lfls_rsp_if.sv =====
`timescale 1ns / 1ps

interface lfls_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  phase;
   logic        shutdown;
   logic [1:0]  event_code;
   logic [4:0]  leaks_in_window;
   logic [15:0] total_leaks;
   logic [31:0] wait_remaining_ms;

   modport source (output valid, phase, shutdown, event_code, leaks_in_window, total_leaks,
                   wait_remaining_ms, input ready);
   modport sink   (input valid, phase, shutdown, event_code, leaks_in_window, total_leaks,
                   wait_remaining_ms, output ready);
endinterface

// ===== rtl/core/leak_fault_lockout_supervisor.sv =====
`timescale 1ns / 1ps

// Leak protection supervisor. Each request is a sample tick, an end-wait command, a
// clear-lock command or a technician reset, and yields exactly one response with the
// phase, shutdown flag, event code, recent leak count, lifetime count and remaining wait.
// An accepted request goes through the apply, ring-walk and finish states; the response
// is registered in the finish state once the output register is free, and the block
// then returns to idle for the next request; finish waits while the output is held. The
// recent-leak count walks the stored leak times through a single read port of the ring
// memory, one entry per cycle, through one shared age comparator. The block accepts no
// request while one is in progress, but takes the next one while the previous response
// still waits in the output register. Configuration writes are taken at any time and
// are meant to be issued only while the block is idle.

module leak_fault_lockout_supervisor import lfls_pkg::*; #(
   parameter int RING_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   lfls_req_if.sink    req_ch,
   lfls_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_APPLY  = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [31:0]   deadline_ff, deadline_in;
   logic [15:0]   total_ff, total_in;
   event_type     ev_ff, ev_in;
   logic          fin_ff, fin_in;

   action_type    act_ff;
   logic          wet_ff;
   logic [31:0]   now_ff;
   logic [31:0]   tsec_ff;

   logic [31:0]   wait_dur_ff, window_sec_ff;
   logic [15:0]   window_lim_ff, total_lim_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   phase_type     rsp_phase_ff;
   logic          rsp_shutdown_ff;
   event_type     rsp_event_ff;
   logic [4:0]    rsp_window_ff;
   logic [15:0]   rsp_total_ff;
   logic [31:0]   rsp_remain_ff;

   ring_ctrl_type ring_ctrl;
   ring_stat_type ring_stat;
   logic [CNT_W-1:0] ring_count;

   logic          req_fire;
   logic          slot_free;
   logic          csr_wr;
   reg_index_type csr_idx;
   logic [15:0]   count_ext;
   logic          lock_hit;
   phase_type     phase_fin;
   event_type     ev_fin;
   logic [4:0]    window_sat;
   logic [31:0]   remain;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   // Configuration port: zero-wait writes and combinational reads.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         REG_WAIT_DURATION: csr_prdata = wait_dur_ff;
         REG_WINDOW_SEC:    csr_prdata = window_sec_ff;
         REG_WINDOW_LIMIT:  csr_prdata = {16'd0, window_lim_ff};
         REG_TOTAL_LIMIT:   csr_prdata = {16'd0, total_lim_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_dur_ff   <= WAIT_DURATION_RST;
         window_sec_ff <= WINDOW_SEC_RST;
         window_lim_ff <= WINDOW_LIMIT_RST;
         total_lim_ff  <= TOTAL_LIMIT_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_WAIT_DURATION: wait_dur_ff   <= csr_pwdata;
            REG_WINDOW_SEC:    window_sec_ff <= csr_pwdata;
            REG_WINDOW_LIMIT:  window_lim_ff <= csr_pwdata[15:0];
            REG_TOTAL_LIMIT:   total_lim_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Final decision once the ring walk is done.
   assign count_ext  = {{(16 - CNT_W){1'b0}}, ring_count};
   assign lock_hit   = (count_ext >= window_lim_ff) || (total_ff >= total_lim_ff);
   assign phase_fin  = fin_ff ? (lock_hit ? PH_LOCK : PH_CLEAR) : phase_ff;
   assign ev_fin     = (fin_ff && lock_hit) ? EV_LEAK_FAULT : ev_ff;
   assign window_sat = (count_ext > {11'd0, WINDOW_CNT_MAX}) ? WINDOW_CNT_MAX : count_ext[4:0];
   assign remain     = (phase_fin == PH_WAIT && now_ff < deadline_ff) ?
                       (deadline_ff - now_ff) : 32'd0;

   // Sequencer: apply the command, walk the ring, then decide and respond.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      deadline_in  = deadline_ff;
      total_in     = total_ff;
      ev_in        = ev_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ring_ctrl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            ev_in          = EV_NONE;
            fin_in         = 1'b0;
            ring_ctrl.scan = 1'b1;
            state_in       = ST_SCAN;
            case (act_ff)
               ACT_TICK: begin
                  if (phase_ff == PH_LOCK) begin
                     phase_in = phase_ff;
                  end else if (wet_ff) begin
                     if (phase_ff == PH_CLEAR) begin
                        phase_in = PH_ACTIVE;
                        ev_in    = EV_LEAK_FAULT;
                     end
                  end else if (phase_ff == PH_ACTIVE) begin
                     ring_ctrl.push = 1'b1;
                     if (total_ff != TOTAL_MAX) begin
                        total_in = total_ff + 16'd1;
                     end
                     phase_in    = PH_WAIT;
                     deadline_in = now_ff + wait_dur_ff;
                     ev_in       = EV_WAIT_START;
                  end else if (phase_ff == PH_WAIT && now_ff >= deadline_ff) begin
                     fin_in      = 1'b1;
                     deadline_in = '0;
                  end
               end
               ACT_END_WAIT: begin
                  deadline_in = '0;
                  if (phase_ff == PH_WAIT) begin
                     fin_in = 1'b1;
                  end
               end
               ACT_CLEAR_LOCK: begin
                  if (phase_ff == PH_LOCK) begin
                     phase_in    = PH_CLEAR;
                     deadline_in = '0;
                  end
               end
               default: begin
                  phase_in        = PH_CLEAR;
                  deadline_in     = '0;
                  total_in        = '0;
                  ring_ctrl.clear = 1'b1;
                  ev_in           = EV_TECH_RESET;
               end
            endcase
         end
         ST_SCAN: begin
            if (ring_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               phase_in     = phase_fin;
               ev_in        = ev_fin;
               fin_in       = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CLEAR;
         deadline_ff  <= '0;
         total_ff     <= '0;
         ev_ff        <= EV_NONE;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         deadline_ff  <= deadline_in;
         total_ff     <= total_in;
         ev_ff        <= ev_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture and response payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff  <= action_type'(req_ch.action);
         wet_ff  <= req_ch.leak_wet;
         now_ff  <= req_ch.now_ms;
         tsec_ff <= req_ch.time_sec;
      end
      if (state_ff == ST_FINISH && slot_free) begin
         rsp_phase_ff    <= phase_fin;
         rsp_shutdown_ff <= (phase_fin != PH_CLEAR);
         rsp_event_ff    <= ev_fin;
         rsp_window_ff   <= window_sat;
         rsp_total_ff    <= total_ff;
         rsp_remain_ff   <= remain;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.phase             = rsp_phase_ff;
   assign rsp_ch.shutdown          = rsp_shutdown_ff;
   assign rsp_ch.event_code        = rsp_event_ff;
   assign rsp_ch.leaks_in_window   = rsp_window_ff;
   assign rsp_ch.total_leaks       = rsp_total_ff;
   assign rsp_ch.wait_remaining_ms = rsp_remain_ff;

   lfls_ring #(
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ring_ctrl),
      .push_sec   (tsec_ff),
      .now_sec    (tsec_ff),
      .window_sec (window_sec_ff),
      .stat       (ring_stat),
      .count      (ring_count)
   );

   // An accepted request always starts the apply step next.
   a_fire_applies: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_APPLY))
      else $error("accepted request did not start apply");

   // A remaining wait is reported only in the dry-out wait phase.
   a_remain_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_remain_ff == '0 || rsp_phase_ff == PH_WAIT))
      else $error("wait time outside wait phase");

   // A technician reset leaves no counted leaks.
   a_tech_reset_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff == EV_TECH_RESET) |->
         (rsp_total_ff == '0 && rsp_window_ff == '0 && rsp_phase_ff == PH_CLEAR))
      else $error("leaks remain after technician reset");

   // A sample tick never releases the hard lock.
   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && act_ff == ACT_TICK && phase_ff == PH_LOCK) |=>
         (phase_ff == PH_LOCK && !fin_ff))
      else $error("sample tick left hard lock");

endmodule

// ===== rtl/core/lfls_ring.sv =====
`timescale 1ns / 1ps

module lfls_ring import lfls_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ring_ctrl_type                  ctrl,
   input  logic [31:0]                    push_sec,
   input  logic [31:0]                    now_sec,
   input  logic [31:0]                    window_sec,
   output ring_stat_type                  stat,
   output logic [$clog2(DEPTH + 1) - 1:0] count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [31:0]      mem [DEPTH];
   logic [31:0]      rd_data_ff;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             scanning_ff, scanning_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;
   logic             issue;
   logic             hit;
   logic [31:0]      age;

   // One read per cycle while entries remain below the fill count.
   assign issue = scanning_ff && (idx_ff < fill_ff);

   // Shared age compare: the entry counts when it is not in the future and
   // no older than the window.
   assign age = now_sec - rd_data_ff;
   assign hit = (now_sec >= rd_data_ff) && (age <= window_sec);

   // Head, fill and scan sequencing.
   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      scanning_in = scanning_ff;
      count_in    = count_ff;
      rd_vld_in   = issue;
      done_in     = scanning_ff && !issue;
      if (ctrl.clear) begin
         head_in = '0;
         fill_in = '0;
      end else if (ctrl.push) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
         if (fill_ff < FULL_CNT) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (rd_vld_ff && hit) begin
         count_in = count_ff + 1'b1;
      end
      if (ctrl.scan) begin
         idx_in      = '0;
         scanning_in = 1'b1;
         count_in    = '0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end else if (scanning_ff) begin
         scanning_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         fill_ff     <= '0;
         idx_ff      <= '0;
         scanning_ff <= 1'b0;
         count_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         idx_ff      <= idx_in;
         scanning_ff <= scanning_in;
         count_ff    <= count_in;
         rd_vld_ff   <= rd_vld_in;
         done_ff     <= done_in;
      end
   end

   // Leak-time memory: one write port for pushes, one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.clear) begin
         mem[head_ff] <= push_sec;
      end
      if (issue) begin
         rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign stat.done = done_ff;
   assign count     = count_ff;

   // The count never exceeds the number of stored entries.
   a_count_le_fill: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (count_ff <= fill_ff))
      else $error("ring count exceeds fill");

   // A push always leaves at least one stored entry.
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push && !ctrl.clear) |=> (fill_ff != '0))
      else $error("ring empty after push");

endmodule
